[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/hltf_pkg.sv]
// ---------------------------------------------------------------------------
// hltf_pkg
// Types and constants of the header/length/tail frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package hltf_pkg;

    localparam int MAX_BODY   = 64;
    localparam int HEADER_LEN = 2;
    localparam int TAIL_LEN   = 2;
    localparam int ADDR_W     = $clog2(MAX_BODY);
    localparam int CNT_W      = $clog2(MAX_BODY + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY,
        PH_TAIL
    } phase_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_t;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] len;
    } start_t;

endpackage

`default_nettype wire

[hdl/hltf_body_buf.sv]
// ---------------------------------------------------------------------------
// hltf_body_buf
// Body store and drain sequencer; the registered memory read is the output word.
// ---------------------------------------------------------------------------
`default_nettype none

module hltf_body_buf (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hltf_pkg::wr_t   wr,
    input  wire hltf_pkg::start_t start,
    output logic                 busy,
    output logic                 body_valid,
    input  wire logic            body_ready,
    output logic [7:0]           body_byte,
    output logic [5:0]           body_index,
    output logic                 last_byte
);
    import hltf_pkg::*;

    logic [7:0]        mem [MAX_BODY];
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [ADDR_W-1:0] rd_ptr_reg;
    logic [ADDR_W-1:0] rd_ptr_next;
    logic              valid_reg;
    logic              valid_next;
    logic [7:0]        byte_reg;
    logic [ADDR_W-1:0] index_reg;
    logic              last_reg;
    logic              issue;

    assign issue = (rem_reg != '0) && (!valid_reg || body_ready);

    always_comb
    begin
        rem_next    = rem_reg;
        rd_ptr_next = rd_ptr_reg;
        valid_next  = valid_reg;
        if (issue)
        begin
            rem_next    = rem_reg - CNT_W'(1);
            rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
            valid_next  = 1'b1;
        end
        else if (body_ready)
        begin
            valid_next = 1'b0;
        end
        if (start.go)
        begin
            rem_next    = start.len;
            rd_ptr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            rd_ptr_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            rem_reg    <= rem_next;
            rd_ptr_reg <= rd_ptr_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            byte_reg  <= mem[rd_ptr_reg];
            index_reg <= rd_ptr_reg;
            last_reg  <= (rem_reg == CNT_W'(1));
        end
    end

    assign busy       = (rem_reg != '0);
    assign body_valid = valid_reg;
    assign body_byte  = byte_reg;
    assign body_index = index_reg;
    assign last_byte  = last_reg;

endmodule

`default_nettype wire

[hdl/header_length_tail_frame_receiver.sv]
// ---------------------------------------------------------------------------
// header_length_tail_frame_receiver
// Header match, length check, body store and tail match; drains the body
// as a run of words once the tail completes.
// ---------------------------------------------------------------------------
//  channel | ports                                         | direction
//  rx      | rx_valid rx_ready rx_byte                     | in
//  body    | body_valid body_ready body_byte body_index    | out
//          | last_byte                                     |
//  cfg     | cfg_we cfg_index cfg_data                     | in
//
//  One rx word per cycle while no body read is outstanding.
//  A completed frame of N bytes drains at one word per cycle while body_ready
//  is high, set by the single read port of the body memory; rx_ready is low
//  until the last body read has issued, so a drain holds rx off.
//  A stall on body holds the output word and the read pointer.
//  Reset clears control state only; the body memory needs no clearing.
// ---------------------------------------------------------------------------
`default_nettype none

module header_length_tail_frame_receiver (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [hltf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [hltf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           rx_valid,
    output logic                                rx_ready,
    input  wire logic [7:0]                     rx_byte,
    output logic                                body_valid,
    input  wire logic                           body_ready,
    output logic [7:0]                          body_byte,
    output logic [5:0]                          body_index,
    output logic                                last_byte
);
    import hltf_pkg::*;

    logic [15:0]      header_reg;
    logic [15:0]      tail_reg;
    logic [6:0]       limit_reg;
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] pos_next;
    logic [7:0]       len_lo_reg;
    logic [7:0]       len_lo_next;
    logic [CNT_W-1:0] body_len_reg;
    logic [CNT_W-1:0] body_len_next;

    logic             rx_fire;
    logic             busy;
    logic [CNT_W-1:0] pos_inc;
    logic             hdr_match;
    logic             tail_match;
    logic [6:0]       lim;
    logic [15:0]      full_len;
    logic             len_bad;
    wr_t              wr;
    start_t           start;

    function automatic logic [7:0] pattern_byte(logic [15:0] pat, logic sel);
        return sel ? pat[15:8] : pat[7:0];
    endfunction

    assign rx_fire    = rx_valid && rx_ready;
    assign pos_inc    = pos_reg + CNT_W'(1);
    assign hdr_match  = (rx_byte == pattern_byte(header_reg, pos_reg[0]));
    assign tail_match = (rx_byte == pattern_byte(tail_reg, pos_reg[0]));
    assign lim        = (limit_reg < 7'(MAX_BODY)) ? limit_reg : 7'(MAX_BODY);
    assign full_len   = {rx_byte, len_lo_reg};
    assign len_bad    = (full_len == 16'd0) || full_len[15] || (full_len > {9'd0, lim});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= '0;
            tail_reg   <= '0;
            limit_reg  <= 7'(MAX_BODY);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEADER: header_reg <= cfg_data;
                REG_TAIL:   tail_reg   <= cfg_data;
                REG_LIMIT:  limit_reg  <= cfg_data[6:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        len_lo_next   = len_lo_reg;
        body_len_next = body_len_reg;
        if (rx_fire)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (!hdr_match)
                    begin
                        pos_next = '0;
                    end
                    else if (pos_inc >= CNT_W'(HEADER_LEN))
                    begin
                        phase_next = PH_LEN;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                    end
                end
                PH_LEN:
                begin
                    if (pos_reg == '0)
                    begin
                        len_lo_next = rx_byte;
                        pos_next    = CNT_W'(1);
                    end
                    else if (len_bad)
                    begin
                        phase_next = PH_HUNT;
                        pos_next   = '0;
                    end
                    else
                    begin
                        phase_next    = PH_BODY;
                        pos_next      = '0;
                        body_len_next = full_len[CNT_W-1:0];
                    end
                end
                PH_BODY:
                begin
                    if (pos_inc >= body_len_reg)
                    begin
                        phase_next = PH_TAIL;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                    end
                end
                PH_TAIL:
                begin
                    if (!tail_match || pos_inc >= CNT_W'(TAIL_LEN))
                    begin
                        phase_next = PH_HUNT;
                        pos_next   = '0;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    pos_next   = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        wr.we     = rx_fire && (phase_reg == PH_BODY);
        wr.addr   = pos_reg[ADDR_W-1:0];
        wr.data   = rx_byte;
        start.go  = rx_fire && (phase_reg == PH_TAIL) && tail_match
                    && (pos_inc >= CNT_W'(TAIL_LEN));
        start.len = body_len_reg;
        rx_ready  = !busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            pos_reg      <= '0;
            len_lo_reg   <= '0;
            body_len_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            len_lo_reg   <= len_lo_next;
            body_len_reg <= body_len_next;
        end
    end

    hltf_body_buf u_body_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .start      (start),
        .busy       (busy),
        .body_valid (body_valid),
        .body_ready (body_ready),
        .body_byte  (body_byte),
        .body_index (body_index),
        .last_byte  (last_byte)
    );

endmodule

`default_nettype wire

[hdl/hltf_checker.sv]
// ---------------------------------------------------------------------------
// hltf_checker
// Port-level checks of the frame receiver's body drain, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hltf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rx_ready,
    input wire logic       body_valid,
    input wire logic       body_ready,
    input wire logic [7:0] body_byte,
    input wire logic [5:0] body_index,
    input wire logic       last_byte
);

    `ASSERT_NEXT(a_hold, body_valid && !body_ready, body_valid && $stable(body_byte) && $stable(body_index) && $stable(last_byte), "body word changed while stalled")
    `ASSERT_NEXT(a_run, body_valid && body_ready && !last_byte, body_valid && (body_index == $past(body_index) + 6'd1), "body run broken")
    `ASSERT_NEXT(a_drain, !rx_ready, body_valid, "rx held without a body word")
    `ASSERT_NOW(a_lock, body_valid && !last_byte, !rx_ready, "rx open during body drain")

endmodule

bind header_length_tail_frame_receiver hltf_checker u_hltf_checker (.*);

`default_nettype wire
